// File: rtl/core/slvu_pkg.sv
`timescale 1ns / 1ps

package slvu_pkg;

    // Item field widths
    localparam int NOW_W      = 32;
    localparam int LEVEL_W    = 64;
    localparam int LVL_SHIFT  = 31;
    localparam int V_W        = LEVEL_W - LVL_SHIFT;   // shifted level, 33 bits
    localparam int COL_W      = 7;

    // Input tdata layout, lowest bits first
    localparam int IN_NOW_LSB   = 0;
    localparam int IN_LL_LSB    = IN_NOW_LSB + NOW_W;
    localparam int IN_LR_LSB    = IN_LL_LSB + LEVEL_W;
    localparam int IN_TDATA_W   = IN_LR_LSB + LEVEL_W;
    localparam int OUT_TDATA_W  = ((2 * COL_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - 2 * COL_W;

    // Configuration registers
    localparam int DECAY_W    = 16;
    localparam int FS_W       = 33;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_START  = 2'd2;

    localparam logic [DECAY_W-1:0] DECAY_MS_RST   = 16'd51;
    localparam logic [FS_W-1:0]    FULL_SCALE_RST = 33'h0_8000_0000;
    localparam logic [COL_W-1:0]   BAR_START_RST  = 7'd88;

    // Scale geometry
    localparam logic [COL_W-1:0] LAST_COLUMN = 7'd127;
    localparam int               DECADES     = 4;
    localparam longint unsigned  P10         = 64'd10 ** DECADES;
    localparam int               FLO_W       = V_W - $clog2(P10) + 1;

    // Log unit: Q.16, integer part is the leading-one index of a V_W-bit value
    localparam int LOG_FRAC   = 16;
    localparam int FRAC_IDX_W = $clog2(LOG_FRAC);
    localparam int LOG_INT_W  = $clog2(V_W);
    localparam int LOG_W      = LOG_INT_W + LOG_FRAC;
    localparam int M_W        = V_W - 1;               // Q1.31 mantissa

    // Shared restoring divider
    localparam int DIV_W      = V_W;
    localparam int DIV_QW     = (FLO_W > COL_W + 1) ? FLO_W : COL_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_QW + 1);
    localparam int NUM_W      = LOG_W + COL_W;

    // Floor divisor, pre-shifted to the top quotient bit
    localparam logic [DIV_W-1:0] FLO_DSH = DIV_W'(P10 << (FLO_W - 1));

endpackage

// File: rtl/core/slvu_log2.sv
`timescale 1ns / 1ps

module slvu_log2 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [slvu_pkg::V_W-1:0]   i_x,
    output logic                       o_done,
    output logic [slvu_pkg::LOG_W-1:0] o_log
);
    import slvu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_SQ   = 2'd2;
    localparam logic [1:0] ST_FIX  = 2'd3;

    logic [1:0]            r_st, n_st;
    logic [V_W-1:0]        r_x, n_x;
    logic [LOG_INT_W-1:0]  r_n, n_n;
    logic [M_W-1:0]        r_m, n_m;
    logic [2*M_W-1:0]      r_prod, n_prod;
    logic [LOG_FRAC-1:0]   r_frac, n_frac;
    logic [FRAC_IDX_W-1:0] r_i, n_i;
    logic                  r_done, n_done;
    logic [M_W:0]          w_sq;

    assign w_sq   = r_prod[2*M_W-1:M_W-1];
    assign o_done = r_done;
    assign o_log  = {r_n, r_frac};

    always_comb begin
        n_st   = r_st;
        n_x    = r_x;
        n_n    = r_n;
        n_m    = r_m;
        n_prod = r_prod;
        n_frac = r_frac;
        n_i    = r_i;
        n_done = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (i_start) begin
                    n_x    = i_x;
                    n_n    = LOG_INT_W'(V_W - 1);
                    n_frac = '0;
                    n_st   = ST_NORM;
                end
            end
            ST_NORM: begin
                // walk the leading one up to the top bit
                if (r_x[V_W-1]) begin
                    n_m  = r_x[V_W-1:1];
                    n_i  = FRAC_IDX_W'(LOG_FRAC - 1);
                    n_st = ST_SQ;
                end else begin
                    n_x = {r_x[V_W-2:0], 1'b0};
                    n_n = r_n - 1'b1;
                end
            end
            ST_SQ: begin
                n_prod = r_m * r_m;
                n_st   = ST_FIX;
            end
            ST_FIX: begin
                // square reached two: emit a one and fold back
                if (w_sq[M_W]) begin
                    n_m         = w_sq[M_W:1];
                    n_frac[r_i] = 1'b1;
                end else begin
                    n_m = w_sq[M_W-1:0];
                end
                if (r_i == '0) begin
                    n_done = 1'b1;
                    n_st   = ST_IDLE;
                end else begin
                    n_i  = r_i - 1'b1;
                    n_st = ST_SQ;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_n    <= n_n;
        r_m    <= n_m;
        r_prod <= n_prod;
        r_frac <= n_frac;
        r_i    <= n_i;
    end

endmodule

// File: rtl/core/slvu_div.sv
`timescale 1ns / 1ps

module slvu_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [slvu_pkg::DIV_W-1:0]     i_rem,
    input  logic [slvu_pkg::DIV_W-1:0]     i_dsh,
    input  logic [slvu_pkg::DIV_CNT_W-1:0] i_steps,
    output logic                           o_done,
    output logic [slvu_pkg::DIV_QW-1:0]    o_quo
);
    import slvu_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_dsh, n_dsh;
    logic [DIV_QW-1:0]    r_q, n_q;

    assign o_done = r_done;
    assign o_quo  = r_q;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_cnt  = i_steps;
                n_rem  = i_rem;
                n_dsh  = i_dsh;
                n_q    = '0;
            end
        end else begin
            // one quotient bit per cycle, most significant first
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_q   = {r_q[DIV_QW-2:0], 1'b1};
            end else begin
                n_q   = {r_q[DIV_QW-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

endmodule

// File: rtl/core/stereo_log_vu_meter_with_decay.sv
`timescale 1ns / 1ps

// Stereo VU meter: maps two raw channel levels onto a logarithmic bar and
// lets each bar fall back one column per decay_ms.
// Input channel (s_axis): one item per refresh tick carrying the time in ms
// and both raw levels. Output channel (m_axis): one item per input item with
// the last lit column of each bar.
// Configuration: write decay_ms, full_scale or bar_start through i_cfg_* while
// the block is idle; an unknown index is dropped. Bars do not move on writes.
// One item at a time: a new item is accepted only once the last one has gone
// to the output register. Time per item is set by the shared log unit (a
// normalize walk, then a square and fold per fraction bit, up to four logs per
// item: floor, full scale and each channel above the floor), by the shared
// shift-subtract divider (20 quotient bits for the floor, 8 per channel offset)
// and by the fall loop, which retires one column per cycle per channel.
// Reset: bars return to column 88, step times to zero, registers to their
// defaults (51 ms, 2^31, 88). s_axis_tready is high from the first cycle after reset.
// Stall: a finished result sits in the output register; the next item is
// accepted meanwhile and its result waits until the register is taken.
module stereo_log_vu_meter_with_decay (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [slvu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slvu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: now_ms[31:0], level_left[95:32], level_right[159:96]
    input  logic [slvu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: bar_end_left[6:0], bar_end_right[13:7], zero pad[15:14]
    output logic [slvu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import slvu_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;   // wait for an item
    localparam logic [3:0] S_FLO   = 4'd1;   // full_scale / 10^DECADES
    localparam logic [3:0] S_LFGO  = 4'd2;
    localparam logic [3:0] S_LF    = 4'd3;   // log of the floor
    localparam logic [3:0] S_LTGO  = 4'd4;
    localparam logic [3:0] S_LT    = 4'd5;   // log of full scale
    localparam logic [3:0] S_CH    = 4'd6;   // classify the channel level
    localparam logic [3:0] S_LV    = 4'd7;   // log of the level, then scale
    localparam logic [3:0] S_DIVGO = 4'd8;
    localparam logic [3:0] S_DV    = 4'd9;   // rounded column offset
    localparam logic [3:0] S_CMP   = 4'd10;  // rise or start falling
    localparam logic [3:0] S_DECAY = 4'd11;  // one column per cycle
    localparam logic [3:0] S_NEXT  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;  // hand over to the output register

    logic [3:0]         r_st, n_st;

    // configuration
    logic [DECAY_W-1:0] r_decay, n_decay;
    logic [FS_W-1:0]    r_fs, n_fs;
    logic [COL_W-1:0]   r_bs, n_bs;

    // per-item working registers
    logic [NOW_W-1:0]   r_now, n_now;
    logic [V_W-1:0]     r_vl, n_vl;
    logic [V_W-1:0]     r_vr, n_vr;
    logic [FLO_W-1:0]   r_flo, n_flo;
    logic [LOG_W-1:0]   r_lf, n_lf;
    logic [LOG_W-1:0]   r_lt, n_lt;
    logic               r_ch, n_ch;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [COL_W-1:0]   r_tgt, n_tgt;

    // channel state
    logic [COL_W-1:0]   r_be [2];
    logic [COL_W-1:0]   n_be [2];
    logic [NOW_W-1:0]   r_lst [2];
    logic [NOW_W-1:0]   n_lst [2];

    // output register
    logic               r_ov, n_ov;
    logic [COL_W-1:0]   r_out_l, n_out_l;
    logic [COL_W-1:0]   r_out_r, n_out_r;

    // shared units
    logic                 log_start, log_done;
    logic [V_W-1:0]       log_x;
    logic [LOG_W-1:0]     log_out;
    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_rem, div_dsh;
    logic [DIV_CNT_W-1:0] div_steps;
    logic [DIV_QW-1:0]    div_quo;

    // helpers
    logic [V_W-1:0]     w_v;
    logic [V_W-1:0]     w_flo_x;
    logic [LOG_W-1:0]   w_den;
    logic [LOG_W-1:0]   w_lvd;
    logic [COL_W-1:0]   w_size;
    logic [NOW_W-1:0]   w_elapsed;
    logic [NOW_W-1:0]   w_decay_x;
    logic [COL_W:0]     w_t;

    slvu_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_out)
    );

    slvu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (div_rem),
        .i_dsh   (div_dsh),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_r, r_out_l};

    assign w_v       = r_ch ? r_vr : r_vl;
    assign w_flo_x   = {{(V_W - FLO_W){1'b0}}, r_flo};
    assign w_den     = (r_lt > r_lf) ? (r_lt - r_lf) : '0;
    assign w_lvd     = log_out - r_lf;
    assign w_size    = (r_bs < LAST_COLUMN) ? (LAST_COLUMN - r_bs) : '0;
    assign w_elapsed = r_now - r_lst[r_ch];
    assign w_decay_x = {{(NOW_W - DECAY_W){1'b0}}, r_decay};
    assign w_t       = {1'b0, r_bs} + {1'b0, div_quo[COL_W-1:0]};

    always_comb begin
        n_st      = r_st;
        n_decay   = r_decay;
        n_fs      = r_fs;
        n_bs      = r_bs;
        n_now     = r_now;
        n_vl      = r_vl;
        n_vr      = r_vr;
        n_flo     = r_flo;
        n_lf      = r_lf;
        n_lt      = r_lt;
        n_ch      = r_ch;
        n_num     = r_num;
        n_tgt     = r_tgt;
        n_be      = r_be;
        n_lst     = r_lst;
        n_ov      = r_ov;
        n_out_l   = r_out_l;
        n_out_r   = r_out_r;
        log_start = 1'b0;
        log_x     = w_v;
        div_start = 1'b0;
        div_rem   = r_fs;
        div_dsh   = FLO_DSH;
        div_steps = DIV_CNT_W'(FLO_W);

        // configuration writes, taken in any state
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DECAY_MS:   n_decay = i_cfg_data[DECAY_W-1:0];
                CFG_FULL_SCALE: n_fs    = i_cfg_data[FS_W-1:0];
                CFG_BAR_START:  n_bs    = i_cfg_data[COL_W-1:0];
                default:        ;
            endcase
        end

        // free the output register once the receiver takes it
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_st)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    // latch the item, drop the low 31 level bits, start the floor
                    n_now     = s_axis_tdata[IN_NOW_LSB +: NOW_W];
                    n_vl      = s_axis_tdata[IN_LL_LSB + LVL_SHIFT +: V_W];
                    n_vr      = s_axis_tdata[IN_LR_LSB + LVL_SHIFT +: V_W];
                    div_start = 1'b1;
                    n_st      = S_FLO;
                end
            end
            S_FLO: begin
                if (div_done) begin
                    n_flo = div_quo[FLO_W-1:0];
                    n_st  = S_LFGO;
                end
            end
            S_LFGO: begin
                // a zero floor counts as one
                log_start = 1'b1;
                log_x     = (r_flo == '0) ? V_W'(1) : w_flo_x;
                n_st      = S_LF;
            end
            S_LF: begin
                if (log_done) begin
                    n_lf = log_out;
                    n_st = S_LTGO;
                end
            end
            S_LTGO: begin
                log_start = 1'b1;
                log_x     = (r_fs == '0) ? V_W'(1) : r_fs;
                n_st      = S_LT;
            end
            S_LT: begin
                if (log_done) begin
                    n_lt = log_out;
                    n_ch = 1'b0;
                    n_st = S_CH;
                end
            end
            S_CH: begin
                if (w_v <= w_flo_x) begin
                    // silence: bar rests at its start
                    n_tgt = r_bs;
                    n_st  = S_CMP;
                end else if (w_den == '0) begin
                    // empty log span: any level above the floor hits the top
                    n_tgt = LAST_COLUMN;
                    n_st  = S_CMP;
                end else begin
                    log_start = 1'b1;
                    log_x     = w_v;
                    n_st      = S_LV;
                end
            end
            S_LV: begin
                if (log_done) begin
                    n_num = {{COL_W{1'b0}}, w_lvd} * {{LOG_W{1'b0}}, w_size};
                    n_st  = S_DIVGO;
                end
            end
            S_DIVGO: begin
                // offset = (2*num + den) / (2*den), rounded half up; the top
                // quotient bit flags an offset that saturates the bar
                div_start = 1'b1;
                div_rem   = DIV_W'({r_num, 1'b0}) + DIV_W'(w_den);
                div_dsh   = DIV_W'(w_den) << (COL_W + 1);
                div_steps = DIV_CNT_W'(COL_W + 1);
                n_st      = S_DV;
            end
            S_DV: begin
                if (div_done) begin
                    if (div_quo[COL_W] || (w_t > {1'b0, LAST_COLUMN})) begin
                        n_tgt = LAST_COLUMN;
                    end else begin
                        n_tgt = w_t[COL_W-1:0];
                    end
                    n_st = S_CMP;
                end
            end
            S_CMP: begin
                if (r_tgt >= r_be[r_ch]) begin
                    // rise at once and stamp the time
                    n_be[r_ch]  = r_tgt;
                    n_lst[r_ch] = r_now;
                    n_st        = S_NEXT;
                end else begin
                    n_st = S_DECAY;
                end
            end
            S_DECAY: begin
                // fall one column per elapsed decay period, stop at the start
                // or one below the target
                if ((w_elapsed >= w_decay_x) && (r_be[r_ch] > r_bs) &&
                    (r_be[r_ch] >= r_tgt)) begin
                    n_lst[r_ch] = r_lst[r_ch] + w_decay_x;
                    n_be[r_ch]  = r_be[r_ch] - 1'b1;
                end else begin
                    n_st = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!r_ch) begin
                    n_ch = 1'b1;
                    n_st = S_CH;
                end else begin
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_out_l = r_be[0];
                    n_out_r = r_be[1];
                    n_st    = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ov     <= 1'b0;
            r_decay  <= DECAY_MS_RST;
            r_fs     <= FULL_SCALE_RST;
            r_bs     <= BAR_START_RST;
            r_be[0]  <= BAR_START_RST;
            r_be[1]  <= BAR_START_RST;
            r_lst[0] <= '0;
            r_lst[1] <= '0;
        end else begin
            r_st    <= n_st;
            r_ov    <= n_ov;
            r_decay <= n_decay;
            r_fs    <= n_fs;
            r_bs    <= n_bs;
            r_be    <= n_be;
            r_lst   <= n_lst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now   <= n_now;
        r_vl    <= n_vl;
        r_vr    <= n_vr;
        r_flo   <= n_flo;
        r_lf    <= n_lf;
        r_lt    <= n_lt;
        r_ch    <= n_ch;
        r_num   <= n_num;
        r_tgt   <= n_tgt;
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
    end

endmodule
